// ===== hdl/tty_line_editor_core_defines.svh =====
// Assertion macros for the terminal line editor.
// With SYNTH defined the macros expand to nothing.
`ifndef TTY_LINE_EDITOR_CORE_DEFINES_SVH
`define TTY_LINE_EDITOR_CORE_DEFINES_SVH

`ifndef SYNTH

// Whenever ante holds at a clock edge, cons must hold at the same edge.
`define TLE_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tle: same-cycle implication violated");

// Whenever ante holds at a clock edge, cons must hold at the next edge.
`define TLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tle: next-cycle implication violated");

`else

`define TLE_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define TLE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/tle_pkg.sv =====
`default_nettype none

package tle_pkg;

   // Default size of the line store.
   localparam int LINE_LEN_DEF = 32;

   // Fixed field widths.
   localparam int BYTE_W    = 8;
   localparam int KIND_W    = 2;
   localparam int POS_W     = 6;
   localparam int MAX_LEN_W = 6;
   localparam int MODE_W    = 4;
   localparam int MAP_W     = 64;
   localparam int MAP_N     = 4;
   localparam int CSR_IDX_W = 3;
   localparam int STR_IDX_W = 3;
   localparam int RP_W      = 5;

   // A reprint echoes at most this many stored bytes.
   localparam int REPRINT_MAX = 31;

   // Register reset values.
   localparam logic [MAX_LEN_W-1:0] MAX_LEN_RST = 6'd32;
   localparam logic [MODE_W-1:0]    MODE_RST    = 4'h0;
   localparam logic [MAP_W-1:0]     TERM_0_RST  = 64'h0000_0000_FEC0_FCEF;
   localparam logic [MAP_W-1:0]     TERM_N_RST  = 64'h0;

   // Mode bit positions.
   localparam int MODE_NO_FILTER = 0;
   localparam int MODE_NO_ECHO   = 1;
   localparam int MODE_NO_TECHO  = 2;
   localparam int MODE_RAW       = 3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TERM_0  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TERM_1  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TERM_2  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TERM_3  = 3'd5;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_ECHO     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_STORE    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd2;

   // Character codes.
   localparam logic [BYTE_W-1:0] CH_EOT   = 8'h04;
   localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_DC2   = 8'h12;
   localparam logic [BYTE_W-1:0] CH_NAK   = 8'h15;
   localparam logic [BYTE_W-1:0] CH_CAN   = 8'h18;
   localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_DOLL  = 8'h24;
   localparam logic [BYTE_W-1:0] CH_R     = 8'h52;
   localparam logic [BYTE_W-1:0] CH_U     = 8'h55;
   localparam logic [BYTE_W-1:0] CH_X     = 8'h58;
   localparam logic [BYTE_W-1:0] CH_CARET = 8'h5E;
   localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
   localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;
   localparam logic [BYTE_W-1:0] CH_CSI   = 8'h9B;
   localparam logic [BYTE_W-1:0] CH_NBSP  = 8'hA0;

   // Canned echo strings.
   typedef enum logic [2:0] {
      STR_CRLF  = 3'd0,
      STR_DOLL  = 3'd1,
      STR_BSB   = 3'd2,
      STR_CTL_R = 3'd3,
      STR_CTL_U = 3'd4,
      STR_CTL_X = 3'd5
   } str_sel_type;

   // Source of one result.
   typedef enum logic [2:0] {
      SRC_STR      = 3'd0,
      SRC_CHAR     = 3'd1,
      SRC_STORE    = 3'd2,
      SRC_REPRINT  = 3'd3,
      SRC_COMPLETE = 3'd4
   } src_type;

   // Result phases that one received byte needs, in output order.
   typedef struct packed {
      logic str;
      logic chr;
      logic store;
      logic rp;
      logic complete;
   } plan_type;

   // Controller to datapath.
   typedef struct packed {
      logic    load;
      logic    plan;
      logic    emit;
      src_type src;
      logic    last;
      logic    rp_read;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      plan_type plan;
      logic     slot_free;
      logic     str_last;
      logic     rp_last;
      logic     count_zero;
   } status_type;

   // Index of the final character of a canned string.
   function automatic logic [STR_IDX_W-1:0] str_last_idx(input str_sel_type sel);
      logic [STR_IDX_W-1:0] r;
      unique case (sel)
         STR_CRLF:  r = 3'd1;
         STR_DOLL:  r = 3'd0;
         STR_BSB:   r = 3'd2;
         default:   r = 3'd4;
      endcase
      return r;
   endfunction

   // Character at position idx of a canned string.
   function automatic logic [BYTE_W-1:0] str_char(input str_sel_type sel,
                                                  input logic [STR_IDX_W-1:0] idx);
      logic [BYTE_W-1:0] letter;
      logic [BYTE_W-1:0] r;
      unique case (sel)
         STR_CTL_R: letter = CH_R;
         STR_CTL_U: letter = CH_U;
         default:   letter = CH_X;
      endcase
      unique case (sel)
         STR_CRLF: r = (idx == 3'd0) ? CH_CR : CH_LF;
         STR_DOLL: r = CH_DOLL;
         STR_BSB:  r = (idx == 3'd1) ? CH_SPACE : CH_BS;
         default: begin
            case (idx)
               3'd0:    r = CH_SPACE;
               3'd1:    r = CH_CARET;
               3'd2:    r = letter;
               3'd3:    r = CH_CR;
               default: r = CH_LF;
            endcase
         end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/tle_ctrl.sv =====
`default_nettype none

module tle_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire tle_pkg::status_type status,
   output tle_pkg::cmd_type         cmd
);
   import tle_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_PLAN     = 8'b0000_0010,
      ST_STR      = 8'b0000_0100,
      ST_CHAR     = 8'b0000_1000,
      ST_STORE    = 8'b0001_0000,
      ST_RP_RD    = 8'b0010_0000,
      ST_RP_OUT   = 8'b0100_0000,
      ST_COMPLETE = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   plan_type  pend_ff, pend_in;
   plan_type  rest;

   // First phase still to run, in result order.
   function automatic state_type first_phase(input plan_type p);
      state_type s;
      if (p.str) begin
         s = ST_STR;
      end else if (p.chr) begin
         s = ST_CHAR;
      end else if (p.store) begin
         s = ST_STORE;
      end else if (p.rp) begin
         s = ST_RP_RD;
      end else if (p.complete) begin
         s = ST_COMPLETE;
      end else begin
         s = ST_IDLE;
      end
      return s;
   endfunction

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      pend_in   = pend_ff;
      rest      = pend_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PLAN;
            end
         end
         ST_PLAN: begin
            cmd.plan = 1'b1;
            pend_in  = status.plan;
            state_in = first_phase(status.plan);
         end
         ST_STR: begin
            rest.str = 1'b0;
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.src  = SRC_STR;
               cmd.last = status.str_last && (rest == '0);
               if (status.str_last) begin
                  pend_in  = rest;
                  state_in = first_phase(rest);
               end
            end
         end
         ST_CHAR: begin
            rest.chr = 1'b0;
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.src  = SRC_CHAR;
               cmd.last = (rest == '0);
               pend_in  = rest;
               state_in = first_phase(rest);
            end
         end
         ST_STORE: begin
            rest.store = 1'b0;
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.src  = SRC_STORE;
               cmd.last = (rest == '0);
               pend_in  = rest;
               state_in = first_phase(rest);
            end
         end
         ST_RP_RD: begin
            cmd.rp_read = 1'b1;
            state_in    = ST_RP_OUT;
         end
         ST_RP_OUT: begin
            rest.rp = 1'b0;
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.src  = SRC_REPRINT;
               cmd.last = status.rp_last && (rest == '0);
               if (status.rp_last) begin
                  pend_in  = rest;
                  state_in = first_phase(rest);
               end else begin
                  state_in = ST_RP_RD;
               end
            end
         end
         ST_COMPLETE: begin
            rest.complete = 1'b0;
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.src  = SRC_COMPLETE;
               cmd.last = (rest == '0);
               pend_in  = rest;
               state_in = first_phase(rest);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tle_dpath.sv =====
`default_nettype none

module tle_dpath #(
   parameter int LINE_LEN = tle_pkg::LINE_LEN_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   input  wire logic [tle_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [tle_pkg::MAP_W-1:0]       csr_wdata,
   input  wire logic [tle_pkg::BYTE_W-1:0]      req_rx_byte,
   input  wire tle_pkg::cmd_type                cmd,
   output tle_pkg::status_type                  status,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_valid,
   output logic [tle_pkg::KIND_W-1:0]           rsp_kind,
   output logic [tle_pkg::BYTE_W-1:0]           rsp_value,
   output logic [tle_pkg::POS_W-1:0]            rsp_position,
   output logic                                 rsp_last
);
   import tle_pkg::*;

   localparam int IDX_W = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
   localparam int CNT_W = $clog2(LINE_LEN + 1);
   localparam int CMP_W = ((CNT_W > MAX_LEN_W) ? CNT_W : MAX_LEN_W) + 1;

   // Configuration.
   logic [MAX_LEN_W-1:0] max_len_ff, max_len_in;
   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic [MAP_W-1:0]     term_map_ff [MAP_N];
   logic [MAP_W-1:0]     term_map_in [MAP_N];

   // Line state and per-byte working registers.
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [BYTE_W-1:0]    rx_ff, rx_in;
   str_sel_type          str_sel_ff, str_sel_in;
   logic [STR_IDX_W-1:0] str_idx_ff, str_idx_in;
   logic [BYTE_W-1:0]    store_val_ff, store_val_in;
   logic [RP_W-1:0]      rp_len_ff, rp_len_in;
   logic [RP_W-1:0]      rp_idx_ff, rp_idx_in;

   // Line store and its read register.
   logic [BYTE_W-1:0]    line_store [LINE_LEN];
   logic [BYTE_W-1:0]    rd_data_ff;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]    rsp_kind_ff, rsp_kind_in;
   logic [BYTE_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [POS_W-1:0]     rsp_pos_ff, rsp_pos_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Decode of the held byte.
   logic                 no_filter, no_echo, no_techo;
   logic                 is_term, is_print;
   logic [CMP_W-1:0]     limit, count_ext;
   logic [IDX_W-1:0]     wr_pos;
   plan_type             dec_plan;
   str_sel_type          dec_str;
   logic [BYTE_W-1:0]    dec_val;
   logic                 dec_bs;
   logic [RP_W-1:0]      dec_rp_len;

   assign no_filter = mode_ff[MODE_NO_FILTER] | mode_ff[MODE_RAW];
   assign no_echo   = mode_ff[MODE_NO_ECHO];
   assign no_techo  = mode_ff[MODE_NO_ECHO] | mode_ff[MODE_NO_TECHO];
   assign is_term   = term_map_ff[rx_ff[7:6]][rx_ff[5:0]];
   assign is_print  = ((rx_ff >= CH_SPACE) && (rx_ff <= CH_TILDE)) || (rx_ff >= CH_NBSP);
   assign count_ext = CMP_W'(count_ff);
   assign wr_pos    = count_ff[IDX_W-1:0];

   always_comb begin
      if (max_len_ff == '0) begin
         limit = CMP_W'(1);
      end else if (CMP_W'(max_len_ff) > CMP_W'(LINE_LEN)) begin
         limit = CMP_W'(LINE_LEN);
      end else begin
         limit = CMP_W'(max_len_ff);
      end
   end

   always_comb begin
      dec_plan   = '0;
      dec_str    = STR_CRLF;
      dec_val    = rx_ff;
      dec_bs     = 1'b0;
      dec_rp_len = (count_ext > CMP_W'(REPRINT_MAX)) ? RP_W'(REPRINT_MAX) : RP_W'(count_ff);
      if (is_term) begin
         // Terminators are honored even with filtering off.
         if ((rx_ff == CH_CR) || (rx_ff == CH_LF)) begin
            dec_plan.str = !no_techo;
            dec_str      = STR_CRLF;
            if (!no_filter) begin
               dec_val = CH_LF;
            end
         end else if ((rx_ff == CH_ESC) || (rx_ff == CH_CSI)) begin
            dec_plan.str = !no_techo;
            dec_str      = STR_DOLL;
         end
         dec_plan.store    = 1'b1;
         dec_plan.complete = 1'b1;
      end else if (!no_filter && (rx_ff == CH_EOT)) begin
         dec_plan.complete = (count_ff == '0);
      end else if (!no_filter && ((rx_ff == CH_BS) || (rx_ff == CH_DEL))) begin
         if (count_ff != '0) begin
            dec_bs       = 1'b1;
            dec_plan.str = !no_echo;
            dec_str      = STR_BSB;
         end
      end else if (!no_filter && (rx_ff == CH_DC2)) begin
         dec_plan.str = !no_echo;
         dec_plan.rp  = !no_echo && (count_ff != '0);
         dec_str      = STR_CTL_R;
      end else if (!no_filter && (rx_ff == CH_NAK)) begin
         dec_plan.str = !no_echo;
         dec_str      = STR_CTL_U;
      end else if (!no_filter && (rx_ff == CH_CAN)) begin
         dec_plan.str = !no_echo;
         dec_str      = STR_CTL_X;
      end else begin
         dec_plan.chr      = !no_echo && is_print;
         dec_plan.store    = 1'b1;
         dec_plan.complete = (count_ext + CMP_W'(1)) >= limit;
      end
   end

   always_comb begin
      status.plan       = dec_plan;
      status.slot_free  = !rsp_valid_ff || rsp_ready;
      status.str_last   = (str_idx_ff == str_last_idx(str_sel_ff));
      status.rp_last    = (rp_idx_ff == (rp_len_ff - RP_W'(1)));
      status.count_zero = (count_ff == '0);
   end

   // Configuration writes.
   always_comb begin
      max_len_in  = max_len_ff;
      mode_in     = mode_ff;
      term_map_in = term_map_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MAX_LEN: max_len_in     = csr_wdata[MAX_LEN_W-1:0];
            CSR_MODE:    mode_in        = csr_wdata[MODE_W-1:0];
            CSR_TERM_0:  term_map_in[0] = csr_wdata;
            CSR_TERM_1:  term_map_in[1] = csr_wdata;
            CSR_TERM_2:  term_map_in[2] = csr_wdata;
            CSR_TERM_3:  term_map_in[3] = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Working registers and the output register.
   always_comb begin
      count_in     = count_ff;
      rx_in        = rx_ff;
      str_sel_in   = str_sel_ff;
      str_idx_in   = str_idx_ff;
      store_val_in = store_val_ff;
      rp_len_in    = rp_len_ff;
      rp_idx_in    = rp_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.load) begin
         rx_in = req_rx_byte;
      end
      if (cmd.plan) begin
         str_sel_in   = dec_str;
         store_val_in = dec_val;
         rp_len_in    = dec_rp_len;
         str_idx_in   = '0;
         rp_idx_in    = '0;
         if (dec_bs) begin
            count_in = count_ff - CNT_W'(1);
         end
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = cmd.last;
         rsp_kind_in  = KIND_ECHO;
         rsp_value_in = '0;
         rsp_pos_in   = '0;
         unique case (cmd.src)
            SRC_STR: begin
               rsp_value_in = str_char(str_sel_ff, str_idx_ff);
               str_idx_in   = str_idx_ff + STR_IDX_W'(1);
            end
            SRC_CHAR: begin
               rsp_value_in = rx_ff;
            end
            SRC_STORE: begin
               rsp_kind_in  = KIND_STORE;
               rsp_value_in = store_val_ff;
               rsp_pos_in   = POS_W'(wr_pos);
               count_in     = CNT_W'(wr_pos) + CNT_W'(1);
            end
            SRC_REPRINT: begin
               rsp_value_in = rd_data_ff;
               rp_idx_in    = rp_idx_ff + RP_W'(1);
            end
            SRC_COMPLETE: begin
               rsp_kind_in = KIND_COMPLETE;
               rsp_pos_in  = POS_W'(count_ff);
               count_in    = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff     <= MAX_LEN_RST;
         mode_ff        <= MODE_RST;
         term_map_ff[0] <= TERM_0_RST;
         term_map_ff[1] <= TERM_N_RST;
         term_map_ff[2] <= TERM_N_RST;
         term_map_ff[3] <= TERM_N_RST;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         max_len_ff   <= max_len_in;
         mode_ff      <= mode_in;
         term_map_ff  <= term_map_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rx_ff        <= rx_in;
      str_sel_ff   <= str_sel_in;
      str_idx_ff   <= str_idx_in;
      store_val_ff <= store_val_in;
      rp_len_ff    <= rp_len_in;
      rp_idx_ff    <= rp_idx_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Line store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.emit && (cmd.src == SRC_STORE)) begin
         line_store[wr_pos] <= store_val_ff;
      end
      if (cmd.rp_read) begin
         rd_data_ff <= line_store[IDX_W'(rp_idx_ff)];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

`default_nettype wire

// ===== hdl/tty_line_editor_core.sv =====
// Terminal line editor. Received bytes enter one transaction at a time on the req_ channel
// and each produces zero to 36 result transactions on the rsp_ channel: echo bytes, bytes
// stored into the line at a position, and a line-complete marker carrying the line length;
// rsp_last flags the final result of a byte. A byte is taken only when the previous one
// has delivered all its results into the output register. Each byte is first loaded
// and decoded, then its results follow in order; a ^R reprint reads each reprinted
// byte through the line store's one registered read port before it is sent; rsp_ready low
// stretches any result. Configuration (line limit, mode bits, 256-bit terminator map)
// is written through the csr_ channel, which is always ready, and must only be written
// while no byte is in flight.
`default_nettype none

`include "tty_line_editor_core_defines.svh"

module tty_line_editor_core #(
   parameter int LINE_LEN = tle_pkg::LINE_LEN_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [tle_pkg::BYTE_W-1:0]      req_rx_byte,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [tle_pkg::KIND_W-1:0]           rsp_kind,
   output logic [tle_pkg::BYTE_W-1:0]           rsp_value,
   output logic [tle_pkg::POS_W-1:0]            rsp_position,
   output logic                                 rsp_last,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [tle_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [tle_pkg::MAP_W-1:0]       csr_wdata
);
   import tle_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Register writes complete in the cycle they are offered.
   assign csr_ready = 1'b1;

   // The controller sequences the result phases of each byte: canned echo string,
   // echo of the byte itself, store, reprint of the line, and line complete.
   tle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the registers, the line store, the byte decode and the
   // output register that decouples the result channel from the sequencer.
   tle_dpath #(
      .LINE_LEN (LINE_LEN)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_rx_byte  (req_rx_byte),
      .cmd          (cmd),
      .status       (status),
      .rsp_ready    (rsp_ready),
      .rsp_valid    (rsp_valid),
      .rsp_kind     (rsp_kind),
      .rsp_value    (rsp_value),
      .rsp_position (rsp_position),
      .rsp_last     (rsp_last)
   );

   // A result is only loaded when the output register is free or being drained.
   `TLE_ASSERT_IMPLIES(a_emit_slot_free, clock, reset, cmd.emit, status.slot_free)

   // After the final result of a byte, the block is ready for the next byte.
   `TLE_ASSERT_NEXT(a_last_then_idle, clock, reset, cmd.emit && cmd.last, req_ready)

   // A completed line always restarts the count at zero.
   `TLE_ASSERT_NEXT(a_complete_clears, clock, reset,
                    cmd.emit && (cmd.src == SRC_COMPLETE), status.count_zero)

endmodule

`default_nettype wire

// ===== verif/tb_tty_line_editor_core.sv =====
`timescale 1ns / 100ps

// Line editor testbench. Received bytes go in on the req_ channel, and every echo,
// store and line-complete transaction that comes back on the rsp_ channel is
// compared field by field with what a local copy of the editor predicts.
// Configuration is only written while no byte is in flight.
module tb_tty_line_editor_core;
   import tle_pkg::*;

   localparam int LINE_LEN       = LINE_LEN_DEF;
   localparam int MAX_EDIT_RES   = 36;
   localparam int SETTLE_CYCLES  = 16;
   localparam int DRAIN_CYCLES   = 64;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int MAX_REPORTS    = 10;

   typedef logic [BYTE_W-1:0] line_byte_type;

   // One result transaction as the editor reports it.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] value;
      logic [POS_W-1:0]  position;
      logic              last;
   } edit_result_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [BYTE_W-1:0]    req_rx_byte;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [KIND_W-1:0]    rsp_kind;
   logic [BYTE_W-1:0]    rsp_value;
   logic [POS_W-1:0]     rsp_position;
   logic                 rsp_last;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [MAP_W-1:0]     csr_wdata;

   // Shadow copy of the editor registers and line state.
   logic [MAX_LEN_W-1:0] cfg_max_len;
   logic [MODE_W-1:0]    cfg_mode;
   logic [MAP_W-1:0]     cfg_term [MAP_N];
   int unsigned          line_count;
   line_byte_type        line_buf [LINE_LEN];

   // Results of the byte being predicted, and all results still owed by the editor.
   edit_result_type step_results [$];
   edit_result_type owed_results [$];

   int  mismatch_count;
   int  stall_cycles;
   int  rsp_hold_left;
   bit  idle_enable;

   tty_line_editor_core u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_kind     (rsp_kind),
      .rsp_value    (rsp_value),
      .rsp_position (rsp_position),
      .rsp_last     (rsp_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Line editor prediction.
   // ------------------------------------------------------------------------

   // Queue one result of the current byte. The editor never reports more than
   // the maximum number of results for a single byte.
   function automatic void note(input logic [KIND_W-1:0] kind, input line_byte_type value,
                                input int unsigned pos);
      edit_result_type r;
      if (step_results.size() < MAX_EDIT_RES) begin
         r.kind     = kind;
         r.value    = value;
         r.position = pos[POS_W-1:0];
         r.last     = 1'b0;
         step_results.push_back(r);
      end
   endfunction

   function automatic void echo_crlf();
      note(KIND_ECHO, CH_CR, 0);
      note(KIND_ECHO, CH_LF, 0);
   endfunction

   // Echo of a control key: space, caret, the letter, then CR LF.
   function automatic void echo_ctl(input line_byte_type letter);
      note(KIND_ECHO, CH_SPACE, 0);
      note(KIND_ECHO, CH_CARET, 0);
      note(KIND_ECHO, letter, 0);
      echo_crlf();
   endfunction

   function automatic void keep_byte(input line_byte_type v);
      int unsigned p;
      p = line_count % LINE_LEN;
      line_buf[p] = v;
      note(KIND_STORE, v, p);
      line_count = p + 1;
   endfunction

   function automatic void end_line(input int unsigned len);
      note(KIND_COMPLETE, '0, len);
      line_count = 0;
   endfunction

   // Work out every result that one received byte causes and add them, in order,
   // to the results owed by the editor.
   function automatic void predict_line_edit(input line_byte_type c);
      logic          no_filter;
      logic          no_echo;
      logic          no_term_echo;
      logic          is_term;
      logic          printable;
      int unsigned   limit;
      int unsigned   n;
      line_byte_type v;
      no_filter    = cfg_mode[MODE_NO_FILTER] | cfg_mode[MODE_RAW];
      no_echo      = cfg_mode[MODE_NO_ECHO];
      no_term_echo = no_echo | cfg_mode[MODE_NO_TECHO];
      limit        = cfg_max_len;
      if (limit == 0) limit = 1;
      if (limit > LINE_LEN) limit = LINE_LEN;
      step_results.delete();
      line_count = line_count % LINE_LEN;
      is_term   = cfg_term[c[7:6]][c[5:0]];
      printable = (c >= CH_SPACE && c <= CH_TILDE) || c >= CH_NBSP;

      if (is_term) begin
         // Terminators win over every editing key, even with filtering off.
         v = c;
         if (c == CH_CR || c == CH_LF) begin
            if (!no_term_echo) echo_crlf();
            if (!no_filter) v = CH_LF;
         end else if (c == CH_ESC || c == CH_CSI) begin
            if (!no_term_echo) note(KIND_ECHO, CH_DOLL, 0);
         end
         keep_byte(v);
         end_line(line_count);
      end else if (!no_filter && c == CH_EOT) begin
         if (line_count == 0) end_line(0);
      end else if (!no_filter && (c == CH_BS || c == CH_DEL)) begin
         if (line_count > 0) begin
            line_count--;
            if (!no_echo) begin
               note(KIND_ECHO, CH_BS, 0);
               note(KIND_ECHO, CH_SPACE, 0);
               note(KIND_ECHO, CH_BS, 0);
            end
         end
      end else if (!no_filter && c == CH_DC2) begin
         if (!no_echo) begin
            echo_ctl(CH_R);
            n = (line_count > REPRINT_MAX) ? REPRINT_MAX : line_count;
            for (int unsigned i = 0; i < n; i++)
               note(KIND_ECHO, line_buf[i], 0);
         end
      end else if (!no_filter && c == CH_NAK) begin
         if (!no_echo) echo_ctl(CH_U);
      end else if (!no_filter && c == CH_CAN) begin
         if (!no_echo) echo_ctl(CH_X);
      end else begin
         if (!no_echo && printable) note(KIND_ECHO, c, 0);
         keep_byte(c);
         if (line_count >= limit) end_line(line_count);
      end

      if (step_results.size() > 0)
         step_results[step_results.size()-1].last = 1'b1;
      foreach (step_results[i]) owed_results.push_back(step_results[i]);
   endfunction

   function automatic void apply_reg(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [MAP_W-1:0] val);
      case (idx)
         CSR_MAX_LEN: cfg_max_len = val[MAX_LEN_W-1:0];
         CSR_MODE:    cfg_mode    = val[MODE_W-1:0];
         CSR_TERM_0:  cfg_term[0] = val;
         CSR_TERM_1:  cfg_term[1] = val;
         CSR_TERM_2:  cfg_term[2] = val;
         CSR_TERM_3:  cfg_term[3] = val;
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Result checking.
   // ------------------------------------------------------------------------

   function automatic void check_result();
      edit_result_type want;
      if (owed_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: unexpected result kind=%0d value=%02h position=%0d last=%0b",
                     $realtime, rsp_kind, rsp_value, rsp_position, rsp_last);
      end else begin
         want = owed_results.pop_front();
         if (rsp_kind !== want.kind || rsp_value !== want.value ||
             rsp_position !== want.position || rsp_last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: result mismatch: expected kind=%0d value=%02h position=%0d",
                        $realtime, want.kind, want.value, want.position,
                        " last=%0b, got kind=%0d value=%02h position=%0d last=%0b",
                        want.last, rsp_kind, rsp_value, rsp_position, rsp_last);
         end
      end
   endfunction

   // Sampled at the edge, so the values are the ones that were set up before it.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_result();
   end

   // The run ends here if no transaction of any kind moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Result receiver. A hold-off request keeps ready low until its count runs out;
   // otherwise ready drops at random while idling is enabled.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_left > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_ready <= !(idle_enable && $urandom_range(99) < 8);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------

   // Offer one byte and predict its results once it is taken. Valid is left high
   // afterwards, so back-to-back bytes never lower and raise it in one step;
   // end_bytes drops it once a burst is over.
   task automatic send_byte(input line_byte_type b);
      if (idle_enable && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      predict_line_edit(b);
   endtask

   // Drop valid and wait until every owed result has come back. A byte that
   // causes no result may still be in decode, so a settling wait follows.
   task automatic end_bytes();
      req_valid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all six registers, in index order. Only called while idle.
   task automatic configure(input logic [MAX_LEN_W-1:0] limit, input logic [MODE_W-1:0] mode,
                            input logic [MAP_W-1:0] m0, input logic [MAP_W-1:0] m1,
                            input logic [MAP_W-1:0] m2, input logic [MAP_W-1:0] m3);
      logic [CSR_IDX_W-1:0] idx  [6];
      logic [MAP_W-1:0]     vals [6];
      idx  = '{CSR_MAX_LEN, CSR_MODE, CSR_TERM_0, CSR_TERM_1, CSR_TERM_2, CSR_TERM_3};
      vals = '{{58'd0, limit}, {60'd0, mode}, m0, m1, m2, m3};
      for (int i = 0; i < 6; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         do @(posedge clock); while (!csr_ready);
         apply_reg(idx[i], vals[i]);
      end
      csr_valid <= 1'b0;
   endtask

   // Mostly text with editing keys and line ends mixed in, plus some fully
   // random bytes so that every code shows up.
   function automatic line_byte_type pick_line_byte();
      int unsigned   r;
      line_byte_type b;
      r = $urandom_range(99);
      if (r < 60) begin
         b = line_byte_type'($urandom_range(CH_SPACE, CH_TILDE));
      end else if (r < 70) begin
         case ($urandom_range(5))
            0:       b = CH_BS;
            1:       b = CH_DEL;
            2:       b = CH_DC2;
            3:       b = CH_NAK;
            4:       b = CH_CAN;
            default: b = CH_EOT;
         endcase
      end else if (r < 78) begin
         case ($urandom_range(3))
            0:       b = CH_CR;
            1:       b = CH_LF;
            2:       b = CH_ESC;
            default: b = CH_CSI;
         endcase
      end else begin
         b = line_byte_type'($urandom_range(255));
      end
      return b;
   endfunction

   // A sparse random map, so that lines are not cut to one byte all the time.
   function automatic logic [MAP_W-1:0] sparse_map();
      return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
   endfunction

   // ------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------

   // Every editing key with the reset configuration: BS on an empty line, EOT on
   // an empty and on a started line, printable and unprintable bytes at the
   // edges of the printable ranges, reprint, kill markers and terminators.
   task automatic test_editing_keys();
      line_byte_type seq [$];
      seq = '{CH_BS, CH_EOT, 8'h41, CH_TILDE, CH_NBSP, 8'hFF, 8'h9F, CH_DEL, CH_DC2,
              CH_NAK, CH_CAN, CH_EOT, CH_CR, 8'h71, CH_LF, CH_ESC, 8'h00, CH_CSI};
      foreach (seq[i]) send_byte(seq[i]);
      end_bytes();
   endtask

   // Mode bits and the line limit at its edges, including a limit lowered in
   // the middle of a line.
   task automatic test_modes_and_limits();
      // Filtering off: CR is stored as is, BS is plain data, CSI is a terminator.
      configure(6'd1, 4'b0001, TERM_0_RST, '0, 64'h0000_0000_0800_0000, '0);
      send_byte(CH_CR);
      send_byte(CH_BS);
      send_byte(CH_CSI);
      end_bytes();
      // Raw input with a zero limit, which behaves as a limit of one.
      configure(6'd0, 4'b1000, TERM_0_RST, '0, '0, '0);
      send_byte(8'h7A);
      send_byte(CH_EOT);
      end_bytes();
      // Terminator echo off, every other echo still on.
      configure(6'd20, 4'b0100, TERM_0_RST, '0, '0, '0);
      send_byte(8'h61);
      send_byte(CH_DC2);
      send_byte(CH_ESC);
      send_byte(CH_CR);
      // A limit lowered below the count ends the line at the next stored byte.
      send_byte(8'h78);
      send_byte(8'h79);
      send_byte(8'h7A);
      end_bytes();
      configure(6'd2, 4'b0010, TERM_0_RST, '0, '0, '0);
      send_byte(8'h77);
      send_byte(CH_DC2);
      end_bytes();
   endtask

   // A limit above the store size acts as the store size. A reprint of a line of
   // 31 bytes gives the largest burst of results, and the next byte fills the line.
   task automatic test_long_reprint();
      configure(6'd63, MODE_RST, TERM_0_RST, TERM_N_RST, TERM_N_RST, TERM_N_RST);
      for (int i = 0; i < LINE_LEN - 1; i++)
         send_byte(line_byte_type'($urandom_range(CH_SPACE, CH_TILDE)));
      send_byte(CH_DC2);
      send_byte(line_byte_type'($urandom_range(CH_SPACE, CH_TILDE)));
      end_bytes();
   endtask

   // Hold the result side off for a long stretch while bytes keep coming, so the
   // editor fills up and stops taking input.
   task automatic test_output_stall();
      configure(6'd32, MODE_RST, TERM_0_RST, TERM_N_RST, TERM_N_RST, TERM_N_RST);
      rsp_hold_left = 300;
      for (int i = 0; i < 12; i++)
         send_byte(line_byte_type'($urandom_range(CH_SPACE, CH_TILDE)));
      send_byte(CH_DC2);
      send_byte(CH_CR);
      end_bytes();
   endtask

   // Random lines over several configurations, the register extremes among them.
   // One phase runs with no idling on either side.
   task automatic test_random_lines();
      logic [MAX_LEN_W-1:0] limit;
      logic [MODE_W-1:0]    mode;
      logic [MAP_W-1:0]     m0;
      logic [MAP_W-1:0]     m1;
      logic [MAP_W-1:0]     m2;
      logic [MAP_W-1:0]     m3;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       limit = 6'd32;
            1:       limit = 6'd1;
            2:       limit = 6'd0;
            3:       limit = 6'd63;
            default: limit = MAX_LEN_W'($urandom_range(2, 40));
         endcase
         case (phase)
            0:       mode = 4'h0;
            1:       mode = 4'hF;
            default: mode = ($urandom_range(1) != 0) ? 4'h0 : MODE_W'($urandom_range(15));
         endcase
         m0 = TERM_0_RST ^ sparse_map();
         m1 = sparse_map();
         m2 = sparse_map();
         m3 = sparse_map();
         if (phase == 2) begin
            m0 = '0; m1 = '0; m2 = '0; m3 = '0;
         end else if (phase == 4) begin
            m0 = '1; m3 = '1;
         end
         configure(limit, mode, m0, m1, m2, m3);
         idle_enable = (phase != 3);
         for (int i = 0; i < 32; i++) send_byte(pick_line_byte());
         end_bytes();
      end
      idle_enable = 1'b1;
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_rx_byte    = '0;
      csr_valid      = 1'b0;
      csr_index      = CSR_MAX_LEN;
      csr_wdata      = '0;
      mismatch_count = 0;
      stall_cycles   = 0;
      rsp_hold_left  = 0;
      idle_enable    = 1'b1;
      cfg_max_len    = MAX_LEN_RST;
      cfg_mode       = MODE_RST;
      cfg_term[0]    = TERM_0_RST;
      cfg_term[1]    = TERM_N_RST;
      cfg_term[2]    = TERM_N_RST;
      cfg_term[3]    = TERM_N_RST;
      line_count     = 0;
      foreach (line_buf[i]) line_buf[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_editing_keys();
      test_modes_and_limits();
      test_long_reprint();
      test_output_stall();
      test_random_lines();

      while (owed_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && owed_results.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
